@@ src/svhm_pkg.sv @@
// Shared types and constants for the supply voltage hysteresis monitor.
// No dependencies; used by the interfaces, the divider and the top level.
package svhm_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned DenW    = 19;
  localparam int unsigned ProdW   = SampleW + DenW;
  localparam int unsigned CntW    = $clog2(ProdW);
  localparam int unsigned MvW     = 16;
  localparam int unsigned HystW   = 10;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [MvW-1:0]  AvgReset   = 16'd3800;
  localparam logic [DenW-1:0] NumReset   = 19'd2;
  localparam logic [DenW-1:0] DenReset   = 19'd1;
  localparam logic [MvW-1:0]  LowThReset = 16'd3700;
  localparam logic [HystW-1:0] LowHyReset = 10'd200;
  localparam logic [MvW-1:0]  UsbThReset = 16'd4400;
  localparam logic [HystW-1:0] UsbHyReset = 10'd100;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LOW     = 3'd1,
    EV_USB_ON  = 3'd2,
    EV_LOW_END = 3'd3,
    EV_USB_END = 3'd4
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM    = 3'd0,
    CFG_DEN    = 3'd1,
    CFG_LOW_TH = 3'd2,
    CFG_LOW_HY = 3'd3,
    CFG_USB_TH = 3'd4,
    CFG_USB_HY = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/svhm_if.sv @@
// Valid/ready channel interfaces for sample beats in and result beats out.
// Depends on svhm_pkg for field widths.
interface svhm_in_if;
  logic                             valid;
  logic                             ready;
  logic [svhm_pkg::SampleW-1:0]     sample_mv;
  logic                             read_failed;

  modport source (output valid, output sample_mv, output read_failed, input ready);
  modport sink   (input valid, input sample_mv, input read_failed, output ready);
endinterface

interface svhm_out_if;
  logic                         valid;
  logic                         ready;
  logic [svhm_pkg::MvW-1:0]     average_mv;
  logic                         batt_low;
  logic                         usb_pwr;
  logic [2:0]                   event_code;

  modport source (output valid, output average_mv, output batt_low,
                  output usb_pwr, output event_code, input ready);
  modport sink   (input valid, input average_mv, input batt_low,
                  input usb_pwr, input event_code, output ready);
endinterface

@@ src/svhm_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on svhm_pkg. A zero divisor yields an all-ones quotient.
module svhm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [svhm_pkg::ProdW-1:0]    dividend_i,
  input  logic [svhm_pkg::DenW-1:0]     divisor_i,
  output logic [svhm_pkg::ProdW-1:0]    quotient_o,
  output svhm_pkg::div_stat_t           stat_o
);

  localparam logic [svhm_pkg::CntW-1:0] LastStep = svhm_pkg::CntW'(svhm_pkg::ProdW - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [svhm_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [svhm_pkg::ProdW-1:0]    acc_q, acc_d;
  logic [svhm_pkg::DenW-1:0]     rem_q, rem_d;
  logic [svhm_pkg::DenW-1:0]     dvs_q, dvs_d;

  logic [svhm_pkg::DenW:0]       rem_sh;
  logic [svhm_pkg::DenW:0]       diff;
  logic                          ge;

  assign rem_sh = {rem_q, acc_q[svhm_pkg::ProdW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // dividend bits shift out the top, quotient bits fill in at the bottom
      acc_d = {acc_q[svhm_pkg::ProdW-2:0], ge};
      rem_d = ge ? diff[svhm_pkg::DenW-1:0] : rem_sh[svhm_pkg::DenW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ src/supply_voltage_hysteresis_monitor_top.sv @@
// Supply voltage monitor: each sample beat yields exactly one result beat with the
// running average, the battery-low and USB-power flags and an event code. A valid
// sample is multiplied by the numerator in the multiply state, then divided in the
// bit-serial divider (one quotient bit per cycle over the 31-bit product), which hands
// over its quotient to the update state, where average and flags are updated.
// A failed read skips the multiply and the divide and goes straight to the update state.
// in_i.ready is high only in the idle state, so a new sample is accepted only after
// the last one has left the update state. A finished result waits in the output
// register without blocking the next sample; only that sample's update cycle stalls
// until the waiting result is taken.
module supply_voltage_hysteresis_monitor_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  svhm_in_if.sink                           in_i,
  svhm_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [svhm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [svhm_pkg::DenW-1:0]         cfg_wdata_i
);

  localparam int unsigned MvW   = svhm_pkg::MvW;
  localparam int unsigned HystW = svhm_pkg::HystW;

  // configuration
  logic [svhm_pkg::DenW-1:0] num_q, den_q;
  logic [MvW-1:0]            low_th_q, usb_th_q;
  logic [HystW-1:0]          low_hy_q, usb_hy_q;

  // sequencer and state
  svhm_pkg::state_e          state_q, state_d;
  logic [svhm_pkg::SampleW-1:0] sample_q;
  logic                      failed_q;
  logic [MvW-1:0]            avg_q;
  logic                      low_q, usb_q;

  // output register
  logic                      out_valid_q;
  logic [MvW-1:0]            out_avg_q;
  logic                      out_low_q, out_usb_q;
  svhm_pkg::event_e          out_ev_q;

  logic                      in_acc, upd_go, div_start;
  logic [svhm_pkg::ProdW-1:0] prod, quot;
  svhm_pkg::div_stat_t       div_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= svhm_pkg::NumReset;
      den_q    <= svhm_pkg::DenReset;
      low_th_q <= svhm_pkg::LowThReset;
      low_hy_q <= svhm_pkg::LowHyReset;
      usb_th_q <= svhm_pkg::UsbThReset;
      usb_hy_q <= svhm_pkg::UsbHyReset;
    end else if (cfg_we_i) begin
      case (svhm_pkg::cfg_idx_e'(cfg_idx_i))
        svhm_pkg::CFG_NUM:    num_q    <= cfg_wdata_i;
        svhm_pkg::CFG_DEN:    den_q    <= cfg_wdata_i;
        svhm_pkg::CFG_LOW_TH: low_th_q <= cfg_wdata_i[MvW-1:0];
        svhm_pkg::CFG_LOW_HY: low_hy_q <= cfg_wdata_i[HystW-1:0];
        svhm_pkg::CFG_USB_TH: usb_th_q <= cfg_wdata_i[MvW-1:0];
        svhm_pkg::CFG_USB_HY: usb_hy_q <= cfg_wdata_i[HystW-1:0];
        default: ;
      endcase
    end
  end

  assign prod = svhm_pkg::ProdW'(sample_q) * svhm_pkg::ProdW'(num_q);

  svhm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (den_q),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      svhm_pkg::ST_IDLE: if (in_acc) begin
        state_d = in_i.read_failed ? svhm_pkg::ST_UPD : svhm_pkg::ST_MUL;
      end
      svhm_pkg::ST_MUL: state_d = svhm_pkg::ST_DIV;
      svhm_pkg::ST_DIV: if (div_stat.done) begin
        state_d = svhm_pkg::ST_UPD;
      end
      svhm_pkg::ST_UPD: if (upd_go) begin
        state_d = svhm_pkg::ST_IDLE;
      end
      default: state_d = svhm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    upd_go     = 1'b0;
    case (state_q)
      svhm_pkg::ST_IDLE: in_i.ready = 1'b1;
      svhm_pkg::ST_MUL:  div_start  = 1'b1;
      svhm_pkg::ST_UPD:  upd_go     = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_acc = in_i.valid && in_i.ready;

  // average and flag update
  logic [MvW-1:0]      v_sat;
  logic signed [17:0]  delta, step, avg_s;
  logic [MvW-1:0]      avg_n;
  logic [MvW:0]        lo_exit;
  logic signed [17:0]  usb_exit;
  logic                low_n, usb_n, bat_trig, usb_trig;
  svhm_pkg::event_e    ev_n;

  always_comb begin
    v_sat = (|quot[svhm_pkg::ProdW-1:MvW]) ? {MvW{1'b1}} : quot[MvW-1:0];
    delta = $signed({2'b00, v_sat}) - $signed({2'b00, avg_q}) + 18'sd2;
    // divide by 4, truncating toward zero
    step  = (delta + (delta[17] ? 18'sd3 : 18'sd0)) >>> 2;
    avg_s = $signed({2'b00, avg_q}) + step;
    if (avg_s[17])
      avg_n = '0;
    else if (avg_s[16])
      avg_n = {MvW{1'b1}};
    else
      avg_n = avg_s[MvW-1:0];

    lo_exit  = {1'b0, low_th_q} + {{(MvW+1-HystW){1'b0}}, low_hy_q};
    usb_exit = $signed({2'b00, usb_th_q}) - $signed({{(18-HystW){1'b0}}, usb_hy_q});

    low_n    = low_q;
    usb_n    = usb_q;
    bat_trig = 1'b0;
    usb_trig = 1'b0;
    if (low_q) begin
      if ({1'b0, avg_n} >= lo_exit) begin low_n = 1'b0; bat_trig = 1'b1; end
      if (avg_n >= usb_th_q)        begin usb_n = 1'b1; usb_trig = 1'b1; end
    end else if (!usb_q) begin
      if (avg_n < low_th_q)         begin low_n = 1'b1; bat_trig = 1'b1; end
      if (avg_n >= usb_th_q)        begin usb_n = 1'b1; usb_trig = 1'b1; end
    end else begin
      if (avg_n < low_th_q)         begin low_n = 1'b1; bat_trig = 1'b1; end
      if ($signed({2'b00, avg_n}) < usb_exit) begin
        usb_n = 1'b0; usb_trig = 1'b1;
      end
    end

    if (bat_trig && low_n)
      ev_n = svhm_pkg::EV_LOW;
    else if (bat_trig)
      ev_n = (usb_trig && usb_n) ? svhm_pkg::EV_USB_ON : svhm_pkg::EV_LOW_END;
    else if (usb_trig && usb_n)
      ev_n = svhm_pkg::EV_USB_ON;
    else if (usb_trig)
      ev_n = svhm_pkg::EV_USB_END;
    else
      ev_n = svhm_pkg::EV_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svhm_pkg::ST_IDLE;
      avg_q       <= svhm_pkg::AvgReset;
      low_q       <= 1'b0;
      usb_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_go) begin
        out_valid_q <= 1'b1;
        if (!failed_q) begin
          avg_q <= avg_n;
          low_q <= low_n;
          usb_q <= usb_n;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.sample_mv;
      failed_q <= in_i.read_failed;
    end
    if (upd_go) begin
      out_avg_q <= failed_q ? avg_q : avg_n;
      out_low_q <= failed_q ? low_q : low_n;
      out_usb_q <= failed_q ? usb_q : usb_n;
      out_ev_q  <= failed_q ? svhm_pkg::EV_NONE : ev_n;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.average_mv = out_avg_q;
  assign out_o.batt_low   = out_low_q;
  assign out_o.usb_pwr    = out_usb_q;
  assign out_o.event_code = out_ev_q;

  // the divider only runs while the sequencer waits on it
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == svhm_pkg::ST_DIV)
    else $error("divider busy outside divide state");

  // a pending result is never overwritten by the update step
  a_upd_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svhm_pkg::ST_UPD && out_valid_q && !out_o.ready)
      |=> state_q == svhm_pkg::ST_UPD)
    else $error("update step ran over a pending result");

  // the low-set event agrees with the flag it reports
  a_ev_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ev_q == svhm_pkg::EV_LOW) |-> out_low_q)
    else $error("low event without low flag");

  a_ev_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_ev_q == svhm_pkg::EV_LOW_END || out_ev_q == svhm_pkg::EV_USB_END))
      |-> !out_low_q)
    else $error("end event while low flag still set");

  // a failed read leaves the running state untouched
  a_fail_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && failed_q) |=> $stable(avg_q) && $stable(low_q) && $stable(usb_q))
    else $error("failed read changed the average or flags");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for supply_voltage_hysteresis_monitor_top: a directed table, then random phases
// with varied register settings. Every result beat is checked against an in-bench model or a typed row's report.
// Depends on svhm_pkg, the channel interfaces in svhm_if.sv and the RTL top level.
module tb;

  localparam int unsigned SampleW = svhm_pkg::SampleW;
  localparam int unsigned DenW    = svhm_pkg::DenW;
  localparam int unsigned MvW     = svhm_pkg::MvW;
  localparam int unsigned HystW   = svhm_pkg::HystW;
  localparam int unsigned CfgIdxW = svhm_pkg::CfgIdxW;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 50;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseBeats   = 192;
  localparam int unsigned MaxShown     = 100;
  localparam int unsigned NDir         = 36;

  typedef struct packed {
    logic [MvW-1:0]   avg;
    logic             low;
    logic             usb;
    svhm_pkg::event_e ev;
  } supply_report_t;

  typedef enum logic {ROW_READ, ROW_CFG} row_kind_e;

  // A read row carries the sample in val; typed rows carry their own expected report.
  typedef struct packed {
    row_kind_e          kind;
    svhm_pkg::cfg_idx_e idx;
    logic [DenW-1:0]    val;
    logic               fail;
    logic               typed;
    supply_report_t     res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [DenW-1:0]     cfg_wdata_i;

  svhm_in_if  in_if ();
  svhm_out_if out_if ();

  supply_voltage_hysteresis_monitor_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register mirror and monitor state
  logic [DenW-1:0]  div_num, div_den;
  logic [MvW-1:0]   low_th, usb_th;
  logic [HystW-1:0] low_hy, usb_hy;
  logic [MvW-1:0]   avg_mv;
  logic             low_flag, usb_flag;

  supply_report_t pending_reports[$];
  supply_report_t next_report;
  int unsigned err_cnt, beat_cnt, fail_cnt, wr_cnt, cycle_cnt;
  int unsigned ev_cnt [5];
  int unsigned burst_left, steady_left;

  function automatic stim_row_t rd(int unsigned s, bit f);
    rd = '{ROW_READ, svhm_pkg::CFG_NUM, DenW'(s), f, 1'b0, '0};
  endfunction

  function automatic stim_row_t rdx(int unsigned s, bit f, int unsigned a, bit l, bit u,
                                    svhm_pkg::event_e e);
    rdx = '{ROW_READ, svhm_pkg::CFG_NUM, DenW'(s), f, 1'b1, '{MvW'(a), l, u, e}};
  endfunction

  function automatic stim_row_t wr_row(svhm_pkg::cfg_idx_e i, int unsigned v);
    wr_row = '{ROW_CFG, i, DenW'(v), 1'b0, 1'b0, '0};
  endfunction

  stim_row_t dir_tab [NDir] = '{
    rdx(4095, 1, 3800, 0, 0, svhm_pkg::EV_NONE),      // failed read leaves everything alone
    rdx(0,    0, 2851, 1, 0, svhm_pkg::EV_LOW),
    rdx(4095, 0, 4186, 0, 0, svhm_pkg::EV_LOW_END),
    rdx(4095, 0, 5187, 0, 1, svhm_pkg::EV_USB_ON),
    rdx(0,    0, 3891, 0, 0, svhm_pkg::EV_USB_END),
    rdx(0,    1, 3891, 0, 0, svhm_pkg::EV_NONE),
    rdx(0,    0, 2919, 1, 0, svhm_pkg::EV_LOW),
    wr_row(svhm_pkg::CFG_NUM, 500000),
    // saturated reading, low ends as usb starts
    rdx(4095, 0, 18573, 0, 1, svhm_pkg::EV_USB_ON),
    rd(4095, 0),
    rd(2048, 0),
    rd(1, 0),
    wr_row(svhm_pkg::CFG_DEN, 0),                     // zero divisor saturates the reading
    rd(0, 0),
    rd(2730, 0),
    wr_row(svhm_pkg::CFG_DEN, 500000),
    wr_row(svhm_pkg::CFG_NUM, 1),
    rd(4095, 0),
    rd(0, 0),
    wr_row(svhm_pkg::CFG_LOW_TH, 65535),              // exit point beyond 16 bits, usb never left
    wr_row(svhm_pkg::CFG_LOW_HY, 1000),
    wr_row(svhm_pkg::CFG_USB_TH, 0),
    wr_row(svhm_pkg::CFG_USB_HY, 1000),
    rd(0, 0),
    rd(4095, 0),
    rd(0, 1),
    wr_row(svhm_pkg::CFG_LOW_TH, 0),
    wr_row(svhm_pkg::CFG_LOW_HY, 0),
    wr_row(svhm_pkg::CFG_USB_TH, 65535),
    wr_row(svhm_pkg::CFG_USB_HY, 0),
    wr_row(svhm_pkg::CFG_NUM, 2),
    wr_row(svhm_pkg::CFG_DEN, 1),
    rd(4095, 0),
    rd(0, 0),
    rd(1365, 0),
    rd(2730, 0)
  };

  // One sample tick: scale, average, hysteresis flags, event code.
  function automatic supply_report_t advance_monitor(logic [SampleW-1:0] s, logic f);
    longint           scaled, avg, delta, lo_l, lo_exit, usb_l, usb_exit;
    logic [63:0]      prod;
    bit               low_hit, usb_hit;
    svhm_pkg::event_e ev;
    ev      = svhm_pkg::EV_NONE;
    low_hit = 1'b0;
    usb_hit = 1'b0;
    if (!f) begin
      if (div_den == '0) begin
        scaled = 65535;
      end else begin
        prod   = 64'(s) * 64'(div_num);
        prod   = prod / 64'(div_den);
        scaled = (prod > 64'd65535) ? 65535 : longint'(prod);
      end
      avg   = avg_mv;
      delta = (scaled - avg + 2) / 4;   // truncates toward zero
      avg   = avg + delta;
      if (avg < 0) avg = 0;
      if (avg > 65535) avg = 65535;
      avg_mv = MvW'(avg);

      lo_l     = low_th;
      lo_exit  = lo_l + longint'(low_hy);
      usb_l    = usb_th;
      usb_exit = usb_l - longint'(usb_hy);
      if (low_flag) begin
        if (avg >= lo_exit) begin low_flag = 1'b0; low_hit = 1'b1; end
        if (avg >= usb_l) begin usb_flag = 1'b1; usb_hit = 1'b1; end
      end else if (!usb_flag) begin
        if (avg < lo_l) begin low_flag = 1'b1; low_hit = 1'b1; end
        if (avg >= usb_l) begin usb_flag = 1'b1; usb_hit = 1'b1; end
      end else begin
        if (avg < lo_l) begin low_flag = 1'b1; low_hit = 1'b1; end
        if (avg < usb_exit) begin usb_flag = 1'b0; usb_hit = 1'b1; end
      end

      if (low_hit && low_flag) ev = svhm_pkg::EV_LOW;
      else if (low_hit)
        ev = (usb_hit && usb_flag) ? svhm_pkg::EV_USB_ON : svhm_pkg::EV_LOW_END;
      else if (usb_hit) ev = usb_flag ? svhm_pkg::EV_USB_ON : svhm_pkg::EV_USB_END;
    end
    return '{avg_mv, low_flag, usb_flag, ev};
  endfunction

  task automatic send_beat(logic [SampleW-1:0] s, logic f, logic typed, supply_report_t want);
    supply_report_t r;
    int unsigned    gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (steady_left > 0) begin
        steady_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        steady_left = $urandom_range(4, 12);
      end else begin
        gap = $urandom_range(1, 8);
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.sample_mv   <= s;
    in_if.read_failed <= f;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = advance_monitor(s, f);
    pending_reports.push_back(typed ? want : r);
    beat_cnt++;
    if (f) fail_cnt++;
  endtask

  task automatic drain_reports(int unsigned settle);
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(svhm_pkg::cfg_idx_e i, int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= i;
    cfg_wdata_i <= DenW'(v);
    case (i)
      svhm_pkg::CFG_NUM:    div_num = DenW'(v);
      svhm_pkg::CFG_DEN:    div_den = DenW'(v);
      svhm_pkg::CFG_LOW_TH: low_th  = MvW'(v);
      svhm_pkg::CFG_LOW_HY: low_hy  = HystW'(v);
      svhm_pkg::CFG_USB_TH: usb_th  = MvW'(v);
      svhm_pkg::CFG_USB_HY: usb_hy  = HystW'(v);
      default: ;
    endcase
    wr_cnt++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pick_settings(int unsigned kind);
    int unsigned num, den, lt, lh, ut, uh, top;
    case (kind)
      0: begin
        num = $urandom_range(1, 4);
        den = $urandom_range(1, 2);
        lt  = $urandom_range(1000, 6000);
        ut  = $urandom_range(2000, 8000);
        lh  = $urandom_range(0, 1000);
        uh  = $urandom_range(0, 1000);
      end
      1: begin
        num = $urandom_range(1, 524287);
        den = $urandom_range(1, 524287);
        lt  = $urandom_range(0, 65535);
        ut  = $urandom_range(0, 65535);
        lh  = $urandom_range(0, 1023);
        uh  = $urandom_range(0, 1023);
      end
      2: begin
        num = $urandom_range(0, 1) ? 500000 : $urandom_range(0, 1);
        den = $urandom_range(0, 1) ? 500000 : $urandom_range(0, 1);
        lt  = $urandom_range(0, 1) ? 65535 : 0;
        ut  = $urandom_range(0, 1) ? 65535 : 0;
        lh  = $urandom_range(0, 1) ? 1000 : ($urandom_range(0, 1) ? 1023 : 0);
        uh  = $urandom_range(0, 1) ? 1000 : ($urandom_range(0, 1) ? 1023 : 0);
      end
      default: begin
        num = $urandom_range(1, 64);
        den = $urandom_range(1, 64);
        top = (4095 * num) / den;
        if (top > 65535) top = 65535;
        lt  = $urandom_range(0, top);
        ut  = $urandom_range(0, top);
        lh  = $urandom_range(0, 1000);
        uh  = $urandom_range(0, 1000);
      end
    endcase
    write_reg(svhm_pkg::CFG_NUM, num);
    write_reg(svhm_pkg::CFG_DEN, den);
    write_reg(svhm_pkg::CFG_LOW_TH, lt);
    write_reg(svhm_pkg::CFG_LOW_HY, lh);
    write_reg(svhm_pkg::CFG_USB_TH, ut);
    write_reg(svhm_pkg::CFG_USB_HY, uh);
  endtask

  // Sample that scales to roughly the given millivolts under the current divider.
  function automatic logic [SampleW-1:0] sample_for_mv(longint mv);
    longint s, n, d;
    if (div_num == '0 || div_den == '0) return SampleW'($urandom_range(0, 4095));
    n = div_num;
    d = div_den;
    if (mv < 0) mv = 0;
    s = (mv * d + n - 1) / n;
    if (s > 4095) s = 4095;
    return SampleW'(s);
  endfunction

  task automatic check_field(string name, logic [MvW-1:0] want, logic [MvW-1:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MaxShown)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxShown)
          $display("%0t: unexpected result beat, expected none, got avg %0d low %0b usb %0b ev %0d",
                   $time, out_if.average_mv, out_if.batt_low, out_if.usb_pwr,
                   out_if.event_code);
      end else begin
        next_report = pending_reports.pop_front();
        ev_cnt[int'(next_report.ev)]++;
        check_field("average_mv", next_report.avg, out_if.average_mv);
        check_field("batt_low", MvW'(next_report.low), MvW'(out_if.batt_low));
        check_field("usb_pwr", MvW'(next_report.usb), MvW'(out_if.usb_pwr));
        check_field("event_code", MvW'(next_report.ev), MvW'(out_if.event_code));
      end
    end
  end

  // receiver stalls: modes of random length
  initial begin
    int unsigned mode, len, phase_cnt;
    logic        rdy;
    out_if.ready <= 1'b0;
    phase_cnt = 0;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(16, 160);
      repeat (len) begin
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 1);
          2:       rdy = ($urandom_range(0, 7) == 0);
          default: rdy = ((phase_cnt % 7) > 2);
        endcase
        phase_cnt++;
        out_if.ready <= rdy;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned sent, run, sel;
    int          base, jit, j;
    longint      mv, r, lo_l, usb_l;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.sample_mv   <= '0;
    in_if.read_failed <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= svhm_pkg::CFG_NUM;
    cfg_wdata_i       <= '0;
    div_num  = svhm_pkg::NumReset;
    div_den  = svhm_pkg::DenReset;
    low_th   = svhm_pkg::LowThReset;
    low_hy   = svhm_pkg::LowHyReset;
    usb_th   = svhm_pkg::UsbThReset;
    usb_hy   = svhm_pkg::UsbHyReset;
    avg_mv   = svhm_pkg::AvgReset;
    low_flag = 1'b0;
    usb_flag = 1'b0;
    burst_left  = 0;
    steady_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        drain_reports(SettleCycles);
        write_reg(dir_tab[k].idx, dir_tab[k].val);
      end else begin
        send_beat(dir_tab[k].val[SampleW-1:0], dir_tab[k].fail, dir_tab[k].typed,
                  dir_tab[k].res);
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain_reports(SettleCycles);
      pick_settings(p % 4);
      sent = 0;
      while (sent < PhaseBeats) begin
        if ($urandom_range(0, 4) == 0) begin
          run = $urandom_range(1, 6);
          repeat (run) begin
            send_beat(SampleW'($urandom()), ($urandom_range(0, 7) == 0), 1'b0, '0);
            sent++;
          end
        end else begin
          // hold the level near one of the switching points so the flags toggle
          lo_l  = low_th;
          usb_l = usb_th;
          r     = $urandom_range(0, 300);
          sel   = $urandom_range(0, 3);
          case (sel)
            0:       mv = lo_l - r;
            1:       mv = lo_l + longint'(low_hy) + r;
            2:       mv = usb_l + r;
            default: mv = usb_l - longint'(usb_hy) - r;
          endcase
          base = sample_for_mv(mv);
          run  = $urandom_range(3, 12);
          repeat (run) begin
            j   = $urandom_range(0, 4);
            jit = base + j - 2;
            if (jit < 0) jit = 0;
            if (jit > 4095) jit = 4095;
            send_beat(SampleW'(jit), ($urandom_range(0, 11) == 0), 1'b0, '0);
            sent++;
          end
        end
        // occasionally hold off until every result is back
        if ($urandom_range(0, 31) == 0) drain_reports(1 + $urandom_range(0, 3));
      end
    end

    drain_reports(TailCycles);
    $display("Checked %0d sample beats, %0d of them failed reads, with %0d register writes.",
             beat_cnt, fail_cnt, wr_cnt);
    $display("Events: none %0d, low %0d, usb on %0d, low ended %0d, usb ended %0d.",
             ev_cnt[0], ev_cnt[1], ev_cnt[2], ev_cnt[3], ev_cnt[4]);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
